// File: rtl/segment_ramp_step_profile_sequencer_defines.svh
// assertion helpers shared by the sequencer rtl
`ifndef SEGMENT_RAMP_STEP_PROFILE_SEQUENCER_DEFINES_SVH
`define SEGMENT_RAMP_STEP_PROFILE_SEQUENCER_DEFINES_SVH

// same-cycle implication, quiet during reset
`define SRSP_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("srsp: same-cycle check failed");

// next-cycle implication, quiet during reset
`define SRSP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("srsp: next-cycle check failed");

`endif

// File: rtl/srsp_pkg.sv
package srsp_pkg;

  localparam int MAX_SEGS   = 64;
  localparam int SEG_ADDR_W = (MAX_SEGS > 1) ? $clog2(MAX_SEGS) : 1;
  localparam int PTR_W      = $clog2(MAX_SEGS + 1);

  localparam int LEVEL_W   = 16;
  localparam int CODE_W    = 12;
  localparam int COUNT_W   = 7;
  localparam int PHASE_W   = 3;
  localparam int TAG_W     = 8;
  localparam int INDEX_W   = 6;
  localparam int NEAR_EPS  = 26;

  // apb side
  localparam int PADDR_W   = 5;
  localparam int PDATA_W   = 32;
  localparam int REG_IDX_W = 3;

  localparam logic [REG_IDX_W-1:0] REG_SEGMENT_COUNT   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_SLEW_STEP       = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_MIN_LEVEL       = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_MAX_LEVEL       = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_NEUTRAL_X       = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_NEUTRAL_Y       = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_BOOT_HOLD_TICKS = 3'd6;

  localparam logic [COUNT_W-1:0] RST_SEGMENT_COUNT   = 7'd32;
  localparam logic [LEVEL_W-1:0] RST_SLEW_STEP       = 16'd52;
  localparam logic [LEVEL_W-1:0] RST_MIN_LEVEL       = 16'd13104;
  localparam logic [LEVEL_W-1:0] RST_MAX_LEVEL       = 16'd55024;
  localparam logic [LEVEL_W-1:0] RST_NEUTRAL_X       = 16'd35269;
  localparam logic [LEVEL_W-1:0] RST_NEUTRAL_Y       = 16'd35237;
  localparam logic [LEVEL_W-1:0] RST_BOOT_HOLD_TICKS = 16'd250;

  localparam logic ACT_TICK  = 1'b0;
  localparam logic ACT_WRITE = 1'b1;

  localparam logic MODE_RAMP = 1'b0;
  localparam logic MODE_STEP = 1'b1;

  typedef enum logic [1:0] {
    ST_BOOT    = 2'd0,
    ST_MOVING  = 2'd1,
    ST_HOLDING = 2'd2,
    ST_DONE    = 2'd3
  } status_t;

  typedef struct packed {
    logic               mode;
    logic [LEVEL_W-1:0] tx;
    logic [LEVEL_W-1:0] ty;
    logic [LEVEL_W-1:0] hold;
    logic [PHASE_W-1:0] phase;
    logic [TAG_W-1:0]   tag;
  } seg_entry_t;

  typedef struct packed {
    logic [CODE_W-1:0]  x_code;
    logic [CODE_W-1:0]  y_code;
    status_t            status;
    logic [PHASE_W-1:0] phase_tag;
    logic [TAG_W-1:0]   step_tag;
  } rsp_t;

endpackage

// File: rtl/srsp_if.sv
interface srsp_req_if;
  logic                         valid;
  logic                         ready;
  logic                         action;
  logic [srsp_pkg::INDEX_W-1:0] seg_index;
  logic                         seg_mode;
  logic [srsp_pkg::LEVEL_W-1:0] seg_target_x;
  logic [srsp_pkg::LEVEL_W-1:0] seg_target_y;
  logic [srsp_pkg::LEVEL_W-1:0] seg_hold_ticks;
  logic [srsp_pkg::PHASE_W-1:0] seg_phase;
  logic [srsp_pkg::TAG_W-1:0]   seg_tag;

  modport source (
    output valid, action, seg_index, seg_mode, seg_target_x, seg_target_y,
           seg_hold_ticks, seg_phase, seg_tag,
    input  ready
  );
  modport sink (
    input  valid, action, seg_index, seg_mode, seg_target_x, seg_target_y,
           seg_hold_ticks, seg_phase, seg_tag,
    output ready
  );
endinterface

interface srsp_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [srsp_pkg::CODE_W-1:0]  x_code;
  logic [srsp_pkg::CODE_W-1:0]  y_code;
  logic [1:0]                   status;
  logic [srsp_pkg::PHASE_W-1:0] phase_tag;
  logic [srsp_pkg::TAG_W-1:0]   step_tag;

  modport source (
    output valid, x_code, y_code, status, phase_tag, step_tag,
    input  ready
  );
  modport sink (
    input  valid, x_code, y_code, status, phase_tag, step_tag,
    output ready
  );
endinterface

// File: rtl/segment_ramp_step_profile_sequencer.sv
// Two-axis setpoint profile generator. Every request is either a tick, which advances the
// sequence (boot hold at neutral, then each table segment ramps or steps to its clamped
// targets and holds, then neutral once the last segment is done), or a write of one
// segment table entry; each request returns exactly one response with the two 12-bit DAC
// codes (level >> 4), the status and the current segment's tags. A request is accepted in
// every cycle while the one-entry skid slot is empty, so the sustained rate is one request
// per clock; its response is registered in the output register, or in the skid slot while the
// output is stalled. The segment table is a 64 x 60 bit synchronous memory with one write port
// and one registered read port: the entry under the pointer is kept in a register and the read
// port always fetches the entry after it, with write-to-read forwarding, so a segment change
// never waits on the memory. Entries read before being written are undefined and there is no
// clearing pass after reset. Registers on the APB port, 32 bit, byte address 4*index:
// 0 segment_count, 1 slew_step, 2 min_level, 3 max_level, 4 neutral_x, 5 neutral_y,
// 6 boot_hold_ticks; write only while no request is in flight.
`include "segment_ramp_step_profile_sequencer_defines.svh"

module segment_ramp_step_profile_sequencer (
  input  logic                          clk,
  input  logic                          rst,
  srsp_req_if.sink                      req,
  srsp_rsp_if.source                    rsp,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [srsp_pkg::PADDR_W-1:0]  paddr,
  input  logic [srsp_pkg::PDATA_W-1:0]  pwdata,
  output logic [srsp_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);

  localparam int LW = srsp_pkg::LEVEL_W;
  localparam int PW = srsp_pkg::PTR_W;
  localparam int AW = srsp_pkg::SEG_ADDR_W;

  // level helpers
  function automatic logic [LW-1:0] clamp_level(input logic [LW-1:0] v,
                                                input logic [LW-1:0] lo,
                                                input logic [LW-1:0] hi);
    // when the limits cross, values below min give min and all others give max
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic [LW-1:0] slew(input logic [LW-1:0] cur,
                                         input logic [LW-1:0] tgt,
                                         input logic [LW-1:0] step);
    logic [LW-1:0] d;
    d = (tgt > cur) ? (tgt - cur) : (cur - tgt);
    if (d <= step) return tgt;
    if (tgt > cur) return cur + step;
    return cur - step;
  endfunction

  function automatic logic near_eq(input logic [LW-1:0] a, input logic [LW-1:0] b);
    logic [LW-1:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return d <= LW'(srsp_pkg::NEAR_EPS);
  endfunction

  // configuration registers
  logic [srsp_pkg::COUNT_W-1:0] segment_count;
  logic [LW-1:0] slew_step, min_level, max_level, neutral_x, neutral_y, boot_hold_ticks;

  logic                              cfg_wr;
  logic [srsp_pkg::REG_IDX_W-1:0]    cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[srsp_pkg::REG_IDX_W+1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      segment_count   <= srsp_pkg::RST_SEGMENT_COUNT;
      slew_step       <= srsp_pkg::RST_SLEW_STEP;
      min_level       <= srsp_pkg::RST_MIN_LEVEL;
      max_level       <= srsp_pkg::RST_MAX_LEVEL;
      neutral_x       <= srsp_pkg::RST_NEUTRAL_X;
      neutral_y       <= srsp_pkg::RST_NEUTRAL_Y;
      boot_hold_ticks <= srsp_pkg::RST_BOOT_HOLD_TICKS;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        srsp_pkg::REG_SEGMENT_COUNT:   segment_count   <= pwdata[srsp_pkg::COUNT_W-1:0];
        srsp_pkg::REG_SLEW_STEP:       slew_step       <= pwdata[LW-1:0];
        srsp_pkg::REG_MIN_LEVEL:       min_level       <= pwdata[LW-1:0];
        srsp_pkg::REG_MAX_LEVEL:       max_level       <= pwdata[LW-1:0];
        srsp_pkg::REG_NEUTRAL_X:       neutral_x       <= pwdata[LW-1:0];
        srsp_pkg::REG_NEUTRAL_Y:       neutral_y       <= pwdata[LW-1:0];
        srsp_pkg::REG_BOOT_HOLD_TICKS: boot_hold_ticks <= pwdata[LW-1:0];
        default: ;  // unmapped address, write dropped
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      srsp_pkg::REG_SEGMENT_COUNT:   prdata = srsp_pkg::PDATA_W'(segment_count);
      srsp_pkg::REG_SLEW_STEP:       prdata = srsp_pkg::PDATA_W'(slew_step);
      srsp_pkg::REG_MIN_LEVEL:       prdata = srsp_pkg::PDATA_W'(min_level);
      srsp_pkg::REG_MAX_LEVEL:       prdata = srsp_pkg::PDATA_W'(max_level);
      srsp_pkg::REG_NEUTRAL_X:       prdata = srsp_pkg::PDATA_W'(neutral_x);
      srsp_pkg::REG_NEUTRAL_Y:       prdata = srsp_pkg::PDATA_W'(neutral_y);
      srsp_pkg::REG_BOOT_HOLD_TICKS: prdata = srsp_pkg::PDATA_W'(boot_hold_ticks);
      default:                       prdata = '0;
    endcase
  end

  // sequencer state
  logic [PW-1:0]       pointer;
  logic [LW-1:0]       x_level, y_level;
  logic                reached;
  logic [LW-1:0]       hold_counter, boot_counter;
  logic                started;
  srsp_pkg::seg_entry_t cur_entry;  // table entry under the pointer
  srsp_pkg::seg_entry_t nxt_entry;  // table entry after the pointer, from the read port

  // response buffer: output register plus one skid slot
  logic           out_valid, skid_valid;
  srsp_pkg::rsp_t out_data, skid_data, rsp_new;

  logic accept, tick, wr_en;
  assign req.ready = !skid_valid;
  assign accept    = req.valid && req.ready;
  assign tick      = accept && (req.action == srsp_pkg::ACT_TICK);
  assign wr_en     = accept && (req.action == srsp_pkg::ACT_WRITE) &&
                     (32'(req.seg_index) < srsp_pkg::MAX_SEGS);

  // entry as stored, targets clamped with the limits of this moment
  srsp_pkg::seg_entry_t new_entry;
  logic [AW-1:0]        wr_addr;
  always_comb begin
    new_entry.mode  = req.seg_mode;
    new_entry.tx    = clamp_level(req.seg_target_x, min_level, max_level);
    new_entry.ty    = clamp_level(req.seg_target_y, min_level, max_level);
    new_entry.hold  = req.seg_hold_ticks;
    new_entry.phase = req.seg_phase;
    new_entry.tag   = req.seg_tag;
  end
  assign wr_addr = AW'(req.seg_index);

  logic [PW-1:0] active_count;
  assign active_count = (32'(segment_count) > srsp_pkg::MAX_SEGS) ?
                        PW'(srsp_pkg::MAX_SEGS) : PW'(segment_count);

  // ramp candidates for the current entry
  logic [LW-1:0] x_slew, y_slew;
  logic          both_near;
  assign x_slew    = clamp_level(slew(x_level, cur_entry.tx, slew_step), min_level, max_level);
  assign y_slew    = clamp_level(slew(y_level, cur_entry.ty, slew_step), min_level, max_level);
  assign both_near = near_eq(x_slew, cur_entry.tx) && near_eq(y_slew, cur_entry.ty);

  logic [PW-1:0] pointer_next;
  logic [LW-1:0] x_level_next, y_level_next, hold_counter_next, boot_counter_next;
  logic          reached_next, started_next, advance;

  always_comb begin
    pointer_next      = pointer;
    x_level_next      = x_level;
    y_level_next      = y_level;
    reached_next      = reached;
    hold_counter_next = hold_counter;
    boot_counter_next = boot_counter;
    started_next      = started;
    advance           = 1'b0;
    if (tick) begin
      if (!started) begin
        // boot hold at neutral
        x_level_next = clamp_level(neutral_x, min_level, max_level);
        y_level_next = clamp_level(neutral_y, min_level, max_level);
        if (boot_counter != '1) boot_counter_next = boot_counter + 1'b1;
        if (boot_counter_next >= boot_hold_ticks) begin
          started_next      = 1'b1;
          pointer_next      = '0;
          reached_next      = 1'b0;
          hold_counter_next = '0;
        end
      end else if (pointer >= active_count) begin
        // past the last segment
        x_level_next = clamp_level(neutral_x, min_level, max_level);
        y_level_next = clamp_level(neutral_y, min_level, max_level);
      end else if (reached) begin
        // hold, then move on without touching the levels
        if (hold_counter != '1) hold_counter_next = hold_counter + 1'b1;
        if (hold_counter_next >= cur_entry.hold) begin
          advance           = 1'b1;
          pointer_next      = pointer + 1'b1;
          reached_next      = 1'b0;
          hold_counter_next = '0;
        end
      end else if (cur_entry.mode == srsp_pkg::MODE_RAMP) begin
        x_level_next = x_slew;
        y_level_next = y_slew;
        if (both_near) begin
          // close enough on both axes: snap to target
          x_level_next      = clamp_level(cur_entry.tx, min_level, max_level);
          y_level_next      = clamp_level(cur_entry.ty, min_level, max_level);
          reached_next      = 1'b1;
          hold_counter_next = '0;
        end
      end else begin
        x_level_next      = clamp_level(cur_entry.tx, min_level, max_level);
        y_level_next      = clamp_level(cur_entry.ty, min_level, max_level);
        reached_next      = 1'b1;
        hold_counter_next = '0;
      end
    end
  end

  // current entry follows the pointer; a write to the entry under it lands at once
  logic                 cur_hit;
  srsp_pkg::seg_entry_t cur_entry_next;
  assign cur_hit = wr_en && (32'(pointer) < srsp_pkg::MAX_SEGS) &&
                   (wr_addr == pointer[AW-1:0]);
  always_comb begin
    if (advance)      cur_entry_next = nxt_entry;
    else if (cur_hit) cur_entry_next = new_entry;
    else              cur_entry_next = cur_entry;
  end

  // read port looks one entry ahead of the next pointer
  logic [PW-1:0] ptr_ahead;
  logic [AW-1:0] rd_addr;
  assign ptr_ahead = pointer_next + 1'b1;
  assign rd_addr   = ptr_ahead[AW-1:0];

  srsp_pkg::seg_entry_t seg_mem [srsp_pkg::MAX_SEGS];

  always_ff @(posedge clk) begin
    if (wr_en) seg_mem[wr_addr] <= new_entry;
  end

  always_ff @(posedge clk) begin
    // forward a write that lands on the entry being fetched
    if (wr_en && (wr_addr == rd_addr)) nxt_entry <= new_entry;
    else                               nxt_entry <= seg_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pointer      <= '0;
      x_level      <= srsp_pkg::RST_NEUTRAL_X;
      y_level      <= srsp_pkg::RST_NEUTRAL_Y;
      reached      <= 1'b0;
      hold_counter <= '0;
      boot_counter <= '0;
      started      <= 1'b0;
    end else begin
      pointer      <= pointer_next;
      x_level      <= x_level_next;
      y_level      <= y_level_next;
      reached      <= reached_next;
      hold_counter <= hold_counter_next;
      boot_counter <= boot_counter_next;
      started      <= started_next;
    end
  end

  always_ff @(posedge clk) begin
    cur_entry <= cur_entry_next;
  end

  // response reflects the state after this request
  always_comb begin
    rsp_new.x_code    = x_level_next[LW-1:LW-srsp_pkg::CODE_W];
    rsp_new.y_code    = y_level_next[LW-1:LW-srsp_pkg::CODE_W];
    rsp_new.phase_tag = '0;
    rsp_new.step_tag  = '0;
    if (!started_next) begin
      rsp_new.status = srsp_pkg::ST_BOOT;
    end else if (pointer_next >= active_count) begin
      rsp_new.status = srsp_pkg::ST_DONE;
    end else begin
      rsp_new.status    = reached_next ? srsp_pkg::ST_HOLDING : srsp_pkg::ST_MOVING;
      rsp_new.phase_tag = cur_entry_next.phase;
      rsp_new.step_tag  = cur_entry_next.tag;
    end
  end

  logic out_free;
  assign out_free = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid  <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_data <= skid_valid ? skid_data : rsp_new;
    end else if (accept) begin
      skid_data <= rsp_new;
    end
  end

  assign rsp.valid     = out_valid;
  assign rsp.x_code    = out_data.x_code;
  assign rsp.y_code    = out_data.y_code;
  assign rsp.status    = out_data.status;
  assign rsp.phase_tag = out_data.phase_tag;
  assign rsp.step_tag  = out_data.step_tag;

  // checks
  `SRSP_ASSERT_IMPL(a_skid_behind_out, clk, rst, skid_valid, out_valid)
  `SRSP_ASSERT_IMPL(a_boot_at_seg0, clk, rst, !started, (pointer == '0) && !reached)
  `SRSP_ASSERT_IMPL(a_ptr_in_range, clk, rst, 1'b1, 32'(pointer) <= srsp_pkg::MAX_SEGS)
  `SRSP_ASSERT_NEXT(a_started_sticks, clk, rst, started, started)
  `SRSP_ASSERT_NEXT(a_write_keeps_levels, clk, rst, accept && !tick, $stable({x_level, y_level}))

endmodule
